// ===== design/tun_pkg.sv =====
package tun_pkg;

    localparam int UW   = 30;   // width of the normalized magnitudes
    localparam int DW   = 33;   // width of an edge difference
    localparam int PW   = 66;   // width of one signed product
    localparam int NW   = 67;   // width of a cross product component
    localparam int SW   = 62;   // width of the sum of squares
    localparam int LW   = 31;   // width of the square root
    localparam int QW   = 15;   // width of a quotient
    localparam int BLW  = 7;    // width of a bit length of a cross component
    localparam logic [QW-1:0] UNIT_ONE = 15'd16384;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
    } tun_in_t;

    typedef struct packed {
        logic signed [15:0] unit_x;
        logic signed [15:0] unit_y;
        logic signed [15:0] unit_z;
        logic               degenerate;
    } tun_out_t;

    typedef logic [UW-1:0] tun_mag_t;

    // Per-word values that ride alongside the root and the quotients.
    typedef struct packed {
        tun_mag_t [2:0] u;
        logic [2:0]     neg;
        logic           degen;
    } tun_side_t;

endpackage

// ===== design/triangle_unit_normal_top.sv =====
// Channel | Signals                       | Word
// --------+-------------------------------+----------------------------------------
// input   | in_valid, in_ready, in_data   | three corners a, b, c, signed Q16.16
// output  | out_valid, out_ready, out_data| unit normal, signed Q2.14, degenerate
//
// One triangle can be accepted on every clock while in_ready is high.
// The pipeline runs through difference, product, cross product and scaling, then the
// square root (one root bit per stage) and then rounding division (one quotient bit per
// stage) with the output register.
// Reset clears only the valid bits; the data registers are not reset.
// When the output word is not taken, the whole pipeline holds and in_ready drops.
module triangle_unit_normal_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tun_pkg::tun_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output tun_pkg::tun_out_t  out_data
);

    // The pipeline advances whenever the output register is empty or being drained.
    logic                   en;
    logic                   f_valid;
    logic [tun_pkg::SW-1:0] f_sum;
    tun_pkg::tun_side_t     f_side;
    logic                   r_valid;
    logic [tun_pkg::LW-1:0] r_root;
    tun_pkg::tun_side_t     r_side;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Differences, cross product, common scaling shift and sum of squares.
    tun_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (f_valid),
        .out_sum   (f_sum),
        .out_side  (f_side)
    );

    // Integer square root of the sum of squares.
    tun_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_sum    (f_sum),
        .in_side   (f_side),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_side  (r_side)
    );

    // Rounded division of each scaled component by the length.
    tun_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .in_root   (r_root),
        .in_side   (r_side),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // A degenerate triangle always reports the zero vector.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.degenerate) |->
            (out_data.unit_x == 16'sd0 && out_data.unit_y == 16'sd0
             && out_data.unit_z == 16'sd0))
        else $error("degenerate word with a nonzero normal");

    // A real normal never has all three components zero.
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.degenerate) |->
            (out_data.unit_x != 16'sd0 || out_data.unit_y != 16'sd0
             || out_data.unit_z != 16'sd0))
        else $error("nondegenerate word with a zero normal");

    // Every component stays within plus or minus one in Q2.14.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (out_data.unit_x <= 16'sd16384 && out_data.unit_x >= -16'sd16384
             && out_data.unit_y <= 16'sd16384 && out_data.unit_y >= -16'sd16384
             && out_data.unit_z <= 16'sd16384 && out_data.unit_z >= -16'sd16384))
        else $error("normal component out of range");

endmodule

// ===== design/tun_front.sv =====
module tun_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  tun_pkg::tun_in_t        in_data,
    output logic                    out_valid,
    output logic [tun_pkg::SW-1:0]  out_sum,
    output tun_pkg::tun_side_t      out_side
);

    // Bit length of a 16-bit group.
    function automatic logic [4:0] bitlen16(input logic [15:0] v);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) begin
                r = 5'(i + 1);
            end
        end
        return r;
    endfunction

    logic [8:0] v_reg;

    logic signed [tun_pkg::DW-1:0] px_reg, py_reg, pz_reg, qx_reg, qy_reg, qz_reg;
    logic signed [tun_pkg::PW-1:0] pr_reg [0:5];
    logic signed [tun_pkg::NW-1:0] n3_reg [0:2];
    logic [tun_pkg::NW-1:0]        m4_reg [0:2];
    logic [tun_pkg::NW-1:0]        m5_reg [0:2];
    logic [tun_pkg::NW-1:0]        m6_reg [0:2];
    logic [2:0]                    neg4_reg, neg5_reg, neg6_reg;
    logic                          dg4_reg, dg5_reg, dg6_reg;
    logic [4:0]                    gnz5_reg;
    logic [4:0]                    gpos5_reg [0:4];
    logic [tun_pkg::BLW-1:0]       bl6_reg;
    tun_pkg::tun_side_t            side7_reg, side8_reg, side9_reg;
    logic [2*tun_pkg::UW-1:0]      sq8_reg [0:2];
    logic [tun_pkg::SW-1:0]        sum9_reg;

    logic signed [tun_pkg::DW-1:0] ax, ay, az;
    logic [79:0]                   all_or;
    logic [tun_pkg::BLW-1:0]       bl_next;
    tun_pkg::tun_side_t            side7_next;
    logic [tun_pkg::NW+tun_pkg::UW-1:0] sh [0:2];

    always_comb
    begin
        ax = tun_pkg::DW'(in_data.a_x);
        ay = tun_pkg::DW'(in_data.a_y);
        az = tun_pkg::DW'(in_data.a_z);
        all_or = {13'd0, m4_reg[0] | m4_reg[1] | m4_reg[2]};
        bl_next = '0;
        for (int g = 0; g < 5; g++) begin
            if (gnz5_reg[g]) begin
                bl_next = tun_pkg::BLW'(g * 16) + tun_pkg::BLW'(gpos5_reg[g]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            // m * 2^30 / 2^bl keeps exactly the top thirty bits of the largest one.
            sh[i] = {m6_reg[i], {tun_pkg::UW{1'b0}}} >> bl6_reg;
            side7_next.u[i] = sh[i][tun_pkg::UW-1:0];
        end
        side7_next.neg   = neg6_reg;
        side7_next.degen = dg6_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[7:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            px_reg <= tun_pkg::DW'(in_data.b_x) - ax;
            py_reg <= tun_pkg::DW'(in_data.b_y) - ay;
            pz_reg <= tun_pkg::DW'(in_data.b_z) - az;
            qx_reg <= tun_pkg::DW'(in_data.c_x) - ax;
            qy_reg <= tun_pkg::DW'(in_data.c_y) - ay;
            qz_reg <= tun_pkg::DW'(in_data.c_z) - az;

            pr_reg[0] <= py_reg * qz_reg;
            pr_reg[1] <= pz_reg * qy_reg;
            pr_reg[2] <= pz_reg * qx_reg;
            pr_reg[3] <= px_reg * qz_reg;
            pr_reg[4] <= px_reg * qy_reg;
            pr_reg[5] <= py_reg * qx_reg;

            for (int i = 0; i < 3; i++) begin
                n3_reg[i] <= tun_pkg::NW'(pr_reg[2*i]) - tun_pkg::NW'(pr_reg[2*i+1]);
            end

            for (int i = 0; i < 3; i++) begin
                neg4_reg[i] <= n3_reg[i][tun_pkg::NW-1];
                m4_reg[i]   <= n3_reg[i][tun_pkg::NW-1] ? tun_pkg::NW'(-n3_reg[i])
                                                        : tun_pkg::NW'(n3_reg[i]);
            end
            dg4_reg <= (n3_reg[0] == '0) && (n3_reg[1] == '0) && (n3_reg[2] == '0);

            for (int g = 0; g < 5; g++) begin
                gnz5_reg[g]  <= |all_or[g*16 +: 16];
                gpos5_reg[g] <= bitlen16(all_or[g*16 +: 16]);
            end
            m5_reg   <= m4_reg;
            neg5_reg <= neg4_reg;
            dg5_reg  <= dg4_reg;

            bl6_reg  <= bl_next;
            m6_reg   <= m5_reg;
            neg6_reg <= neg5_reg;
            dg6_reg  <= dg5_reg;

            side7_reg <= side7_next;

            for (int i = 0; i < 3; i++) begin
                sq8_reg[i] <= side7_reg.u[i] * side7_reg.u[i];
            end
            side8_reg <= side7_reg;

            sum9_reg  <= tun_pkg::SW'(sq8_reg[0]) + tun_pkg::SW'(sq8_reg[1])
                       + tun_pkg::SW'(sq8_reg[2]);
            side9_reg <= side8_reg;
        end
    end

    assign out_valid = v_reg[8];
    assign out_sum   = sum9_reg;
    assign out_side  = side9_reg;

endmodule

// ===== design/tun_sqrt.sv =====
module tun_sqrt (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [tun_pkg::SW-1:0]  in_sum,
    input  tun_pkg::tun_side_t      in_side,
    output logic                    out_valid,
    output logic [tun_pkg::LW-1:0]  out_root,
    output tun_pkg::tun_side_t      out_side
);

    localparam int N = tun_pkg::LW;

    // Stage k holds the state after k result bits; stage 0 is the input.
    logic [N:0]               v;
    logic [tun_pkg::SW-1:0]   s    [0:N];
    logic [32:0]              rem  [0:N];
    logic [N-1:0]             root [0:N];
    tun_pkg::tun_side_t       side [0:N];

    assign v[0]    = in_valid;
    assign s[0]    = in_sum;
    assign rem[0]  = '0;
    assign root[0] = '0;
    assign side[0] = in_side;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [34:0] cur;
        logic [34:0] trial;
        logic        take;
        logic        v_reg;
        logic [tun_pkg::SW-1:0] s_reg;
        logic [32:0]            rem_reg;
        logic [N-1:0]           root_reg;
        tun_pkg::tun_side_t     side_reg;

        always_comb
        begin
            cur   = {rem[k], s[k][tun_pkg::SW-1 -: 2]};
            trial = {2'b00, root[k], 2'b01};
            take  = cur >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                s_reg    <= {s[k][tun_pkg::SW-3:0], 2'b00};
                rem_reg  <= take ? 33'(cur - trial) : cur[32:0];
                root_reg <= {root[k][N-2:0], take};
                side_reg <= side[k];
            end
        end

        assign v[k+1]    = v_reg;
        assign s[k+1]    = s_reg;
        assign rem[k+1]  = rem_reg;
        assign root[k+1] = root_reg;
        assign side[k+1] = side_reg;
    end

    assign out_valid = v[N];
    assign out_root  = root[N];
    assign out_side  = side[N];

    // A nondegenerate word is scaled so that its root is at least 2^29.
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (v[N] && !side[N].degen) |-> out_root[N-1 -: 2] != 2'b00)
        else $error("square root below 2^29 for a nondegenerate word");

endmodule

// ===== design/tun_div.sv =====
module tun_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [tun_pkg::LW-1:0]  in_root,
    input  tun_pkg::tun_side_t      in_side,
    output logic                    out_valid,
    output tun_pkg::tun_out_t       out_data
);

    localparam int Q  = tun_pkg::QW;
    localparam int RW = tun_pkg::UW + Q + 1;   // numerator width

    logic [Q+1:0]         v;
    logic [RW-1:0]        rem  [0:Q][0:2];
    logic [Q-1:0]         quo  [0:Q][0:2];
    logic [tun_pkg::LW:0] dvs  [0:Q];
    logic [2:0]           neg  [0:Q];
    logic                 dg   [0:Q];

    // Entry stage: numerator u * 2^15 + L, divisor 2L.
    logic                 v0_reg;
    logic [RW-1:0]        num0_reg [0:2];
    logic [tun_pkg::LW:0] d0_reg;
    logic [2:0]           neg0_reg;
    logic                 dg0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                num0_reg[i] <= {1'b0, in_side.u[i], {Q{1'b0}}} + RW'(in_root);
            end
            d0_reg   <= {in_root, 1'b0};
            neg0_reg <= in_side.neg;
            dg0_reg  <= in_side.degen;
        end
    end

    assign v[0]   = v0_reg;
    assign dvs[0] = d0_reg;
    assign neg[0] = neg0_reg;
    assign dg[0]  = dg0_reg;
    for (genvar i = 0; i < 3; i++) begin : g_init
        assign rem[0][i] = num0_reg[i];
        assign quo[0][i] = '0;
    end

    // Stage j settles quotient bit Q-1-j in all three lanes.
    for (genvar j = 0; j < Q; j++) begin : g_stage
        localparam int K = Q - 1 - j;
        logic                 v_reg;
        logic [RW-1:0]        rem_reg [0:2];
        logic [Q-1:0]         quo_reg [0:2];
        logic [tun_pkg::LW:0] d_reg;
        logic [2:0]           neg_reg;
        logic                 dg_reg;
        logic [RW:0]          sub [0:2];

        always_comb
        begin
            for (int i = 0; i < 3; i++) begin
                sub[i] = {1'b0, rem[j][i]} - ((RW+1)'(dvs[j]) << K);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= v[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    rem_reg[i] <= sub[i][RW] ? rem[j][i] : sub[i][RW-1:0];
                    quo_reg[i] <= quo[j][i] | (Q'(!sub[i][RW]) << K);
                end
                d_reg   <= dvs[j];
                neg_reg <= neg[j];
                dg_reg  <= dg[j];
            end
        end

        assign v[j+1]   = v_reg;
        assign dvs[j+1] = d_reg;
        assign neg[j+1] = neg_reg;
        assign dg[j+1]  = dg_reg;
        for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem[j+1][i] = rem_reg[i];
            assign quo[j+1][i] = quo_reg[i];
        end
    end

    // Output stage: clamp, sign and degenerate handling.
    logic              out_v_reg;
    tun_pkg::tun_out_t out_reg;
    tun_pkg::tun_out_t out_next;
    logic [15:0]       comp [0:2];
    logic [Q-1:0]      mag;

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            mag     = (quo[Q][i] > tun_pkg::UNIT_ONE) ? tun_pkg::UNIT_ONE : quo[Q][i];
            comp[i] = dg[Q] ? 16'd0 : (neg[Q][i] ? 16'(-{1'b0, mag}) : {1'b0, mag});
        end
        out_next.unit_x     = comp[0];
        out_next.unit_y     = comp[1];
        out_next.unit_z     = comp[2];
        out_next.degenerate = dg[Q];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= v[Q];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign v[Q+1]    = out_v_reg;
    assign out_valid = v[Q+1];
    assign out_data  = out_reg;

endmodule
